>>> hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is low.
`define SSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define SSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/sss_pkg.sv
// Types, needle table and constants of the string signature scanner.
package sss_pkg;

  localparam int NumNeedles   = 39;
  localparam int NumClasses   = 14;
  localparam int MaxNeedleLen = 28;
  localparam int HistTaps     = MaxNeedleLen - 1;
  localparam int LenWidth     = 10;
  localparam int ClassWidth   = 4;
  localparam int IndexWidth   = 6;
  localparam int SevWidth     = 4;

  localparam logic [LenWidth-1:0] LenMax     = 10'd1023;
  localparam logic [LenWidth-1:0] LimitReset = 10'd512;

  // Register select on paddr[2].
  localparam logic RegLengthLimit = 1'b0;

  // Needle text, right aligned: byte 0 is the last character.
  typedef logic [MaxNeedleLen*8-1:0] needle_text_t;

  localparam needle_text_t NeedleText [NumNeedles] = '{
    "DexClassLoader", "PathClassLoader", "InMemoryDexClassLoader", "loadDex",
    "dalvik.system.DexFile", "System.loadLibrary", "Runtime.exec",
    "ProcessBuilder", "/bin/sh", "/system/bin/sh", "su", "SmsManager",
    "sendTextMessage", "sendMultipartTextMessage", {"ACTION_", "CALL"},
    "TelephonyManager", "DevicePolicyManager", "wipeData", "lockNow",
    "resetPassword", "AccessibilityService", "performGlobalAction",
    "findFocusedViewInWindow", {"TYPE_APPLICATION_", "OVERLAY"},
    {"TYPE_SYSTEM_", "ALERT"},
    "MediaRecorder", "AudioRecord", "ClipboardManager",
    "OnPrimaryClipChangedListener", "AccountManager", "getAuthToken",
    "invalidateAuthToken", "PackageInstaller", "installPackage", "MD5", "DES",
    "DESede", "RC4", "ECB"
  };

  localparam logic [ClassWidth-1:0] NeedleClass [NumNeedles] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7,
    4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10, 4'd11, 4'd11, 4'd11,
    4'd12, 4'd12, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13
  };

  localparam logic [SevWidth-1:0] NeedleSev [NumNeedles] = '{
    4'd8, 4'd6, 4'd9, 4'd7, 4'd7, 4'd5, 4'd8, 4'd7, 4'd9, 4'd9, 4'd8,
    4'd7, 4'd8, 4'd8, 4'd7, 4'd5, 4'd8, 4'd10, 4'd9, 4'd9, 4'd7, 4'd8,
    4'd8, 4'd9, 4'd8, 4'd6, 4'd7, 4'd6, 4'd7, 4'd7, 4'd9, 4'd8,
    4'd8, 4'd9, 4'd5, 4'd7, 4'd5, 4'd7, 4'd6
  };

  // Character count of a needle: position of its highest nonzero byte.
  function automatic int needle_len(needle_text_t text);
    int n;
    n = 0;
    for (int k = 0; k < MaxNeedleLen; k++) begin
      if (text[8*k +: 8] != 8'h00) n = k + 1;
    end
    return n;
  endfunction

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       new_file;
  } in_beat_t;

  typedef struct packed {
    logic [ClassWidth-1:0] threat_class;
    logic [IndexWidth-1:0] pattern_index;
    logic [SevWidth-1:0]   severity;
  } out_beat_t;

  typedef struct packed {
    logic      hit;
    out_beat_t beat;
  } pick_t;

endpackage

>>> hw/rtl/sss_matcher.sv
// Parallel needle comparators against the current byte and the byte history.
module sss_matcher #(
  parameter int NUM_USED = 39
) (
  input  logic [7:0]                         cur_i,
  input  logic [sss_pkg::HistTaps-1:0][7:0]  hist_i,
  output logic [NUM_USED-1:0]                hit_o
);
  import sss_pkg::*;

  for (genvar g = 0; g < NUM_USED; g++) begin : g_needle
    localparam int Len = needle_len(NeedleText[g]);
    logic hit;

    // Last character against the current byte, the rest against history.
    always_comb begin
      hit = (cur_i == NeedleText[g][7:0]);
      for (int k = 1; k < MaxNeedleLen; k++) begin
        if (k < Len) hit = hit & (hist_i[k-1] == NeedleText[g][8*k +: 8]);
      end
    end

    assign hit_o[g] = hit;
  end

endmodule

>>> hw/rtl/sss_picker.sv
// Lowest-numbered found needle whose class is not yet reported.
module sss_picker #(
  parameter int NUM_USED = 39
) (
  input  logic [NUM_USED-1:0]            found_i,
  input  logic [sss_pkg::NumClasses-1:0] reported_i,
  output sss_pkg::pick_t                 pick_o
);
  import sss_pkg::*;

  logic [NUM_USED-1:0] eligible;

  always_comb begin
    for (int i = 0; i < NUM_USED; i++) begin
      eligible[i] = found_i[i] & ~reported_i[NeedleClass[i]];
    end
  end

  // Scan down so the lowest eligible index wins.
  always_comb begin
    pick_o = '0;
    for (int i = NUM_USED - 1; i >= 0; i--) begin
      if (eligible[i]) begin
        pick_o.hit                = 1'b1;
        pick_o.beat.threat_class  = NeedleClass[i];
        pick_o.beat.pattern_index = IndexWidth'(i);
        pick_o.beat.severity      = NeedleSev[i];
      end
    end
  end

endmodule

>>> hw/rtl/string_signature_scanner.sv
// Top level of the string signature scanner: input stage, scan state, result stage.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_stall_o   in_beat_i  (data_byte, last_byte, new_file)
//   out      out  out_valid_o/out_stall_i out_beat_o (threat_class, pattern_index, severity)
//   cfg      in   APB psel/penable/pready paddr[2] selects length_limit
//
// One beat per cycle while no stalled result is held; a result passes through the input
// register and then the result register, with the needle comparators and the priority pick
// as the logic between them; the scan state updates together with the result register.
// Reset clears the history, found flags, length, reported classes and both stages' valid
// flags, and loads length_limit with 512.
// A stalled result holds the result register; the input register still takes one beat
// and stalls upstream only once both stages are full.
module string_signature_scanner #(
  parameter int HISTORY_BYTES = 27,
  parameter int NUM_PATTERNS  = 39
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sss_pkg::in_beat_t   in_beat_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sss_pkg::out_beat_t  out_beat_o,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import sss_pkg::*;

  // Needles past the table end do not exist.
  localparam int NumUsed = (NUM_PATTERNS < NumNeedles) ? NUM_PATTERNS : NumNeedles;

  // Input stage.
  logic     in_valid_q, in_valid_d;
  in_beat_t in_beat_q;
  logic     in_take;
  logic     advance;

  // Scan state.
  logic [HISTORY_BYTES-1:0][7:0] hist_q, hist_d;
  logic [NumUsed-1:0]            found_q, found_d;
  logic [LenWidth-1:0]           len_q, len_d;
  logic [NumClasses-1:0]         rep_q, rep_d;
  logic [LenWidth-1:0]           limit_q;

  // Result stage.
  logic      out_valid_q, out_valid_d;
  out_beat_t out_beat_q;

  logic [NumUsed-1:0]    hits;
  logic [NumUsed-1:0]    found_all;
  logic [LenWidth-1:0]   len_inc;
  logic [NumClasses-1:0] rep_base;
  pick_t                 pick;
  logic                  emit;
  logic                  cfg_write;

  // Retire the held beat whenever the result slot is free or draining.
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign in_valid_d = in_take | (in_valid_q & ~advance);

  sss_matcher #(
    .NUM_USED (NumUsed)
  ) u_matcher (
    .cur_i  (in_beat_q.data_byte),
    .hist_i (hist_q[HistTaps-1:0]),
    .hit_o  (hits)
  );

  assign found_all = found_q | hits;
  assign len_inc   = (len_q == LenMax) ? len_q : len_q + 1'b1;
  // A new file drops the reported set before this byte is judged.
  assign rep_base  = in_beat_q.new_file ? '0 : rep_q;

  sss_picker #(
    .NUM_USED (NumUsed)
  ) u_picker (
    .found_i    (found_all),
    .reported_i (rep_base),
    .pick_o     (pick)
  );

  // Report only at the end of a string short enough to scan.
  assign emit = in_beat_q.last_byte & (len_inc <= limit_q) & pick.hit;

  always_comb begin
    rep_d = rep_base;
    if (emit) rep_d = rep_base | (NumClasses'(1) << pick.beat.threat_class);
  end

  // Advance the per-string state, or clear it after the last byte.
  always_comb begin
    if (in_beat_q.last_byte) begin
      hist_d  = '0;
      found_d = '0;
      len_d   = '0;
    end else begin
      hist_d  = {hist_q[HISTORY_BYTES-2:0], in_beat_q.data_byte};
      found_d = found_all;
      len_d   = len_inc;
    end
  end

  assign out_valid_d = (advance & emit) | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_q      <= '0;
      found_q     <= '0;
      len_q       <= '0;
      rep_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        hist_q  <= hist_d;
        found_q <= found_d;
        len_q   <= len_d;
        rep_q   <= rep_d;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) in_beat_q <= in_beat_i;
    if (advance && emit) out_beat_q <= pick.beat;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // Configuration port: zero wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == RegLengthLimit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_write) begin
      limit_q <= pwdata[LenWidth-1:0];
    end
  end

  assign prdata = (paddr[2] == RegLengthLimit) ? {{(32-LenWidth){1'b0}}, limit_q} : '0;

endmodule

>>> hw/rtl/sss_checker.sv
// Port-level assertions for the string signature scanner, bound to the top level.
`include "assert_macros.svh"

module sss_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input sss_pkg::out_beat_t out_beat_o,
  input logic               pready
);
  import sss_pkg::*;

  // A result names a real needle and carries that needle's class and severity.
  `SSS_ASSERT(a_result_matches_table, out_valid_o |-> (out_beat_o.pattern_index < IndexWidth'(NumNeedles)) && (NeedleClass[out_beat_o.pattern_index] == out_beat_o.threat_class) && (NeedleSev[out_beat_o.pattern_index] == out_beat_o.severity), "result fields disagree with the needle table")

  // Hold a stalled result.
  `SSS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o), "stalled result changed")

  // Upstream stalls only behind a stalled result.
  `SSS_ASSERT(a_in_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled while result side is free")

  `SSS_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule

bind string_signature_scanner sss_checker u_sss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o),
  .pready      (pready)
);
